/* src/dtp_pkg.sv */
// Shared types, constants and helpers for the display test pattern pixel generator.
`timescale 1ns / 1ps
package dtp_pkg;

    localparam int MARGIN    = 20;
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int POS_W     = 15;
    localparam int OFF_W     = COORD_W + 3;
    localparam int THR_W     = 16;
    localparam int LVL_W     = 8;
    localparam int CH_W      = 8;
    localparam int BANDS     = 8;
    localparam int BAND_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [SIZE_W-1:0]             w;
        logic [SIZE_W-1:0]             h;
        t_pos                          xr;
        t_pos                          yb;
        t_pos                          wm1;
        t_pos                          hm1;
        t_pos                          wmh;
        logic [BANDS-2:0][THR_W-1:0]   thr;
    } t_cfg;

    typedef enum logic [2:0] {
        RGN_BLACK = 3'd0,
        RGN_WHITE = 3'd1,
        RGN_BLUE  = 3'd2,
        RGN_RED   = 3'd3,
        RGN_BAND  = 3'd4
    } t_region;

    typedef struct packed {
        logic              on_line;
        logic              x_box;
        logic              y_box;
        logic              x_lo;
        logic              x_hi;
        logic              y_lo;
        logic              y_hi;
        logic              in_cols;
        logic              in_rows;
        logic              diag;
        logic [OFF_W-1:0]  off8;
        logic [LVL_W-1:0]  lvl;
    } t_geom;

    typedef struct packed {
        t_region           region;
        logic [BANDS-2:0]  thermo;
        logic [LVL_W-1:0]  lvl;
    } t_mid;

    function automatic t_cfg f_cfg(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        t_cfg             c;
        logic [THR_W-1:0] den;
        c.w   = w;
        c.h   = h;
        c.xr  = t_pos'({2'b00, w}) - t_pos'(MARGIN + 1);
        c.yb  = t_pos'({2'b00, h}) - t_pos'(MARGIN + 1);
        c.wm1 = t_pos'({2'b00, w}) - t_pos'(1);
        c.hm1 = t_pos'({2'b00, h}) - t_pos'(1);
        c.wmh = t_pos'({2'b00, w}) - t_pos'({2'b00, h});
        den   = {3'b000, w} - THR_W'(2 * MARGIN + 2);
        for (int k = 0; k < BANDS - 1; k++) begin
            c.thr[k] = THR_W'(den * THR_W'(k + 1));
        end
        return c;
    endfunction

endpackage

/* src/display_test_pattern_pixel_top.sv */
// Top level of the display test pattern pixel generator.
// Pipeline: three register stages (geometry, region, shade); an accepted beat passes
// through them in that order to the output.
// Throughput: one beat per cycle while the output is not stalled; each stage advances
// when empty or when the stage after it advances, so bubbles close up under output stall.
// Reset: synchronous active-low; clears all stage valids and loads 640 x 480.
`timescale 1ns / 1ps
module display_test_pattern_pixel_top
    import dtp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COORD_W-1:0]   i_col,
    input  logic [COORD_W-1:0]   i_row,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CH_W-1:0]      o_red,
    output logic [CH_W-1:0]      o_green,
    output logic [CH_W-1:0]      o_blue,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_wdata
);

    t_cfg  cfg;
    t_geom geom;
    t_mid  mid;
    logic  geom_valid;
    logic  mid_valid;
    logic  en1;
    logic  en2;
    logic  en3;

    assign en3     = !o_valid || !i_stall;
    assign en2     = !mid_valid || en3;
    assign en1     = !geom_valid || en2;
    assign o_stall = !en1;

    dtp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dtp_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_valid),
        .i_col   (i_col),
        .i_row   (i_row),
        .i_cfg   (cfg),
        .o_valid (geom_valid),
        .o_geom  (geom)
    );

    dtp_region u_region (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (geom_valid),
        .i_geom  (geom),
        .i_cfg   (cfg),
        .o_valid (mid_valid),
        .o_mid   (mid)
    );

    dtp_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (mid_valid),
        .i_mid   (mid),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

/* src/dtp_cfg.sv */
// Frame size registers and the geometry derived from them.
`timescale 1ns / 1ps
module dtp_cfg
    import dtp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg              r_cfg;
    logic [SIZE_W-1:0] n_w;
    logic [SIZE_W-1:0] n_h;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_w = r_cfg.w;
        n_h = r_cfg.h;
        if (i_cfg_valid && i_cfg_index == CFG_FRAME_WIDTH) begin
            n_w = i_cfg_wdata;
        end
        if (i_cfg_valid && i_cfg_index == CFG_FRAME_HEIGHT) begin
            n_h = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= f_cfg(FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
        end else if (i_cfg_valid) begin
            r_cfg <= f_cfg(n_w, n_h);
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/dtp_geom.sv */
// First stage: coordinate compares against margins, edges and diagonals.
`timescale 1ns / 1ps
module dtp_geom
    import dtp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output t_geom              o_geom
);

    logic               r_valid;
    t_geom              r_geom;
    t_geom              n_geom;
    t_pos               xs;
    t_pos               ys;
    t_pos               xl;
    logic [SIZE_W-1:0]  sum;
    logic [COORD_W-1:0] off;

    always_comb begin
        xs  = t_pos'({3'b000, i_col});
        ys  = t_pos'({3'b000, i_row});
        xl  = t_pos'(MARGIN);
        sum = {1'b0, i_col} + {1'b0, i_row};
        off = i_col - COORD_W'(MARGIN + 1);

        n_geom.on_line = (xs == xl) || (xs == i_cfg.xr) || (ys == xl) || (ys == i_cfg.yb);
        n_geom.x_box   = (xs == t_pos'(0)) || (xs == i_cfg.wm1);
        n_geom.y_box   = (ys == t_pos'(0)) || (ys == i_cfg.hm1);
        n_geom.x_lo    = xs < xl;
        n_geom.x_hi    = xs > i_cfg.xr;
        n_geom.y_lo    = ys < xl;
        n_geom.y_hi    = ys > i_cfg.yb;
        n_geom.in_cols = (xs > xl) && (xs < i_cfg.xr);
        n_geom.in_rows = (ys > xl) && (ys < i_cfg.yb);
        n_geom.diag    = (xs == ys) || ((xs - ys) == i_cfg.wmh)
                       || (sum == i_cfg.w) || (sum == i_cfg.h);
        n_geom.off8    = {off, 3'b000};
        n_geom.lvl     = LVL_W'(i_row - COORD_W'(MARGIN + 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom <= n_geom;
        end
    end

    assign o_valid = r_valid;
    assign o_geom  = r_geom;

endmodule

/* src/dtp_region.sv */
// Second stage: region priority and band thresholds.
`timescale 1ns / 1ps
module dtp_region
    import dtp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_geom i_geom,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_mid  o_mid
);

    logic r_valid;
    t_mid r_mid;
    t_mid n_mid;

    always_comb begin
        for (int k = 0; k < BANDS - 1; k++) begin
            n_mid.thermo[k] = {1'b0, i_geom.off8} >= i_cfg.thr[k];
        end
        n_mid.lvl = i_geom.lvl;

        if (i_geom.on_line) begin
            n_mid.region = RGN_WHITE;
        end else if (i_geom.x_box && (i_geom.y_lo || i_geom.y_hi)) begin
            n_mid.region = RGN_WHITE;
        end else if (i_geom.y_box && (i_geom.x_lo || i_geom.x_hi)) begin
            n_mid.region = RGN_WHITE;
        end else if (i_geom.x_lo && i_geom.in_rows) begin
            n_mid.region = RGN_BLUE;
        end else if (i_geom.y_lo && i_geom.in_cols) begin
            n_mid.region = RGN_BLUE;
        end else if (i_geom.x_hi && i_geom.in_rows) begin
            n_mid.region = RGN_RED;
        end else if (i_geom.y_hi && i_geom.in_cols) begin
            n_mid.region = RGN_RED;
        end else if (i_geom.in_cols && i_geom.in_rows) begin
            n_mid.region = i_geom.diag ? RGN_WHITE : RGN_BAND;
        end else begin
            n_mid.region = RGN_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_valid = r_valid;
    assign o_mid   = r_mid;

endmodule

/* src/dtp_shade.sv */
// Third stage: band decode and color mapping into the output register.
`timescale 1ns / 1ps
module dtp_shade
    import dtp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_mid            i_mid,
    output logic            o_valid,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue
);

    localparam logic [BANDS-1:0][2:0] BAND_MASK = {
        3'b000, 3'b111, 3'b110, 3'b101, 3'b011, 3'b001, 3'b010, 3'b100
    };

    logic              r_valid;
    logic [CH_W-1:0]   r_red;
    logic [CH_W-1:0]   r_green;
    logic [CH_W-1:0]   r_blue;
    logic [CH_W-1:0]   n_red;
    logic [CH_W-1:0]   n_green;
    logic [CH_W-1:0]   n_blue;
    logic [BAND_W-1:0] band;
    logic [2:0]        mask;

    always_comb begin
        band = '0;
        for (int k = 0; k < BANDS - 1; k++) begin
            band = band + BAND_W'(i_mid.thermo[k]);
        end
        mask = BAND_MASK[band];

        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        case (i_mid.region)
            RGN_WHITE: begin
                n_red   = '1;
                n_green = '1;
                n_blue  = '1;
            end
            RGN_BLUE: begin
                n_blue = '1;
            end
            RGN_RED: begin
                n_red = '1;
            end
            RGN_BAND: begin
                n_red   = mask[2] ? i_mid.lvl : '0;
                n_green = mask[1] ? i_mid.lvl : '0;
                n_blue  = mask[0] ? i_mid.lvl : '0;
            end
            default: begin
                n_red   = '0;
                n_green = '0;
                n_blue  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

/* src/dtp_checker.sv */
// Port-level checker for the test pattern generator, bound to the top level.
`timescale 1ns / 1ps
module dtp_checker
    import dtp_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [CH_W-1:0] o_red,
    input logic [CH_W-1:0] o_green,
    input logic [CH_W-1:0] o_blue
);

    logic in_beat;

    assign in_beat = i_valid && !o_stall;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green)
                               && $stable(o_blue))
        else $error("stalled output beat changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled output beat");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_beat && !i_stall) ##1 (!in_beat && !i_stall) ##1 (!in_beat && !i_stall)
        |=> !o_valid)
        else $error("output beat without a matching input beat");

endmodule

bind display_test_pattern_pixel_top dtp_checker u_chk (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the display test pattern pixel generator.
`timescale 1ns / 1ps
module tb_top;
    import dtp_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               typed;
        t_rgb               px;
    } t_probe;

    localparam t_rgb PX_WHITE = '{8'hFF, 8'hFF, 8'hFF};
    localparam t_rgb PX_BLUE  = '{8'h00, 8'h00, 8'hFF};
    localparam t_rgb PX_RED   = '{8'hFF, 8'h00, 8'h00};
    localparam t_rgb PX_BLACK = '{8'h00, 8'h00, 8'h00};

    // red, green, blue enables per band, band 0 at the right
    localparam logic [BANDS-1:0][2:0] BAND_MIX =
        {3'b000, 3'b111, 3'b110, 3'b101, 3'b011, 3'b001, 3'b010, 3'b100};

    localparam int MAX_GAP      = 5;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 93;
    localparam int PROBES       = 25;

    localparam t_probe PROBE_TBL [PROBES] = '{
        '{12'd20,   12'd100,  1'b1, PX_WHITE},
        '{12'd619,  12'd100,  1'b1, PX_WHITE},
        '{12'd100,  12'd20,   1'b1, PX_WHITE},
        '{12'd100,  12'd459,  1'b1, PX_WHITE},
        '{12'd0,    12'd0,    1'b1, PX_WHITE},
        '{12'd0,    12'd100,  1'b1, PX_BLUE},
        '{12'd100,  12'd5,    1'b1, PX_BLUE},
        '{12'd630,  12'd100,  1'b1, PX_RED},
        '{12'd100,  12'd470,  1'b1, PX_RED},
        '{12'd5,    12'd5,    1'b1, PX_BLACK},
        '{12'd4095, 12'd4095, 1'b1, PX_BLACK},
        '{12'd4095, 12'd0,    1'b1, PX_WHITE},
        '{12'd100,  12'd100,  1'b1, PX_WHITE},
        '{12'd300,  12'd140,  1'b1, PX_WHITE},
        '{12'd400,  12'd240,  1'b1, PX_WHITE},
        '{12'd200,  12'd280,  1'b1, PX_WHITE},
        '{12'd40,   12'd300,  1'b0, PX_BLACK},
        '{12'd120,  12'd300,  1'b0, PX_BLACK},
        '{12'd200,  12'd300,  1'b0, PX_BLACK},
        '{12'd280,  12'd300,  1'b0, PX_BLACK},
        '{12'd360,  12'd300,  1'b0, PX_BLACK},
        '{12'd440,  12'd300,  1'b0, PX_BLACK},
        '{12'd520,  12'd300,  1'b0, PX_BLACK},
        '{12'd600,  12'd300,  1'b0, PX_BLACK},
        '{12'd600,  12'd277,  1'b0, PX_BLACK}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [COORD_W-1:0]   i_col       = '0;
    logic [COORD_W-1:0]   i_row       = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [CH_W-1:0]      o_red;
    logic [CH_W-1:0]      o_green;
    logic [CH_W-1:0]      o_blue;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FRAME_WIDTH;
    logic [SIZE_W-1:0]    i_cfg_wdata = '0;

    logic [SIZE_W-1:0] cur_width  = FRAME_WIDTH_RST;
    logic [SIZE_W-1:0] cur_height = FRAME_HEIGHT_RST;
    t_rgb              pending_px [$];
    int                mismatches  = 0;
    int                idle_cycles = 0;
    bit                no_idle     = 1'b0;
    bit                hold_req    = 1'b0;

    display_test_pattern_pixel_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_col       (i_col),
        .i_row       (i_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_rgb pattern_pixel(input logic [COORD_W-1:0] col,
                                           input logic [COORD_W-1:0] row);
        int   x, y, w, h, xr, yb, den, band, lvl;
        bit   in_rows, in_cols;
        t_rgb px;
        x       = col;
        y       = row;
        w       = cur_width;
        h       = cur_height;
        xr      = w - MARGIN - 1;
        yb      = h - MARGIN - 1;
        in_rows = (y > MARGIN) && (y < yb);
        in_cols = (x > MARGIN) && (x < xr);
        px      = PX_BLACK;
        if (x == MARGIN || x == xr || y == MARGIN || y == yb) begin
            px = PX_WHITE;
        end else if ((x == 0 || x == w - 1) && (y < MARGIN || y > yb)) begin
            px = PX_WHITE;
        end else if ((y == 0 || y == h - 1) && (x < MARGIN || x > xr)) begin
            px = PX_WHITE;
        end else if ((x < MARGIN && in_rows) || (y < MARGIN && in_cols)) begin
            px = PX_BLUE;
        end else if ((x > xr && in_rows) || (y > yb && in_cols)) begin
            px = PX_RED;
        end else if (in_cols && in_rows) begin
            if (x == y || w - x == h - y || w - x == y || x == h - y) begin
                px = PX_WHITE;
            end else begin
                den  = xr - MARGIN - 1;
                band = (den > 0) ? ((x - MARGIN - 1) * 8) / den : 0;
                lvl  = (y - MARGIN - 1) & 255;
                px.red   = BAND_MIX[band][2] ? CH_W'(lvl) : '0;
                px.green = BAND_MIX[band][1] ? CH_W'(lvl) : '0;
                px.blue  = BAND_MIX[band][0] ? CH_W'(lvl) : '0;
            end
        end
        return px;
    endfunction

    // bias toward margins, box edges and diagonals of the current frame
    function automatic void pick_coord(output logic [COORD_W-1:0] col,
                                       output logic [COORD_W-1:0] row);
        int w, h, wl, hl, sel;
        w   = cur_width;
        h   = cur_height;
        wl  = (w >= 1 && w <= 4096) ? w : 4096;
        hl  = (h >= 1 && h <= 4096) ? h : 4096;
        col = COORD_W'($urandom_range(0, wl - 1));
        row = COORD_W'($urandom_range(0, hl - 1));
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            col = COORD_W'($urandom);
            row = COORD_W'($urandom);
        end else if (sel < 35) begin
            case ($urandom_range(0, 10))
                0:       col = COORD_W'(MARGIN);
                1:       col = COORD_W'(w - MARGIN - 1);
                2:       col = row;
                3:       col = COORD_W'(w - h + int'(row));
                4:       col = COORD_W'(w - int'(row));
                5:       col = COORD_W'(h - int'(row));
                6:       row = COORD_W'(MARGIN);
                7:       row = COORD_W'(h - MARGIN - 1);
                8:       col = '0;
                9:       col = COORD_W'(w - 1);
                default: row = (sel[0]) ? '0 : COORD_W'(h - 1);
            endcase
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input logic typed, input t_rgb typed_px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_col   <= col;
        i_row   <= row;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_px.push_back(typed ? typed_px : pattern_pixel(col, row));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_wdata <= w;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cur_width    = w;
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_wdata <= h;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cur_height   = h;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input bit rush);
        logic [COORD_W-1:0] col, row;
        wait_drained();
        write_frame(w, h);
        no_idle  = rush;
        hold_req = rush;
        repeat (PHASE_ITEMS) begin
            pick_coord(col, row);
            send_pixel(col, row, 1'b0, PX_BLACK);
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (PROBE_TBL[k]) begin
            send_pixel(PROBE_TBL[k].col, PROBE_TBL[k].row, PROBE_TBL[k].typed,
                       PROBE_TBL[k].px);
        end
        run_phase(13'd640, 13'd480, 1'b0);
        run_phase(13'd64, 13'd64, 1'b1);
        run_phase(13'd4096, 13'd4096, 1'b0);
        run_phase(13'd8191, 13'd8191, 1'b0);
        run_phase(13'd0, 13'd0, 1'b0);
        run_phase(13'd43, 13'd50, 1'b0);
        run_phase(13'd1920, 13'd1080, 1'b1);
        run_phase(SIZE_W'($urandom_range(64, 4096)), SIZE_W'($urandom_range(64, 4096)), 1'b0);
        run_phase(SIZE_W'($urandom), SIZE_W'($urandom), 1'b0);
        run_phase(13'd4096, 13'd64, 1'b0);
        run_phase(13'd64, 13'd4096, 1'b0);
        wait_drained();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : sink
        int   stall_cycles;
        t_rgb want;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_req) begin
                stall_cycles = HOLD_CYCLES;
                hold_req     = 1'b0;
            end else begin
                stall_cycles = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (stall_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_px.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = pending_px.pop_front();
                if (o_red !== want.red) begin
                    report_mismatch($sformatf("red got %0d want %0d", o_red, want.red));
                end
                if (o_green !== want.green) begin
                    report_mismatch($sformatf("green got %0d want %0d", o_green, want.green));
                end
                if (o_blue !== want.blue) begin
                    report_mismatch($sformatf("blue got %0d want %0d", o_blue, want.blue));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) ||
                     (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
